### hw/rtl/csp_pkg.sv
package csp_pkg;

    localparam int NLANE = 5;
    localparam int NSQ   = 32;
    localparam int NDIV  = 32;

    // divider lanes
    localparam int LN_RX = 0;
    localparam int LN_RZ = 1;
    localparam int LN_MX = 2;
    localparam int LN_MY = 3;
    localparam int LN_MZ = 4;

    // configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SIN    = 2'd2;

    localparam logic [30:0] RST_RADIUS = 31'd65536;
    localparam logic [30:0] RST_HEIGHT = 31'd65536;
    localparam logic [15:0] RST_SIN    = 16'd29309;

    localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
    localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

    typedef struct packed {
        logic [30:0] radius;
        logic [30:0] height;
        logic [15:0] sin_apex;
    } t_cfg;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] num;
    } t_sq;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] q;
    } t_dv;

    typedef struct packed {
        logic               sx;
        logic               sy;
        logic               sz;
        logic signed [31:0] y;
        logic [30:0]        m;
        logic [NLANE-1:0][62:0] prod;
    } t_sq_side;

    typedef struct packed {
        logic        sx;
        logic        sy;
        logic        sz;
        logic        apex;
        logic        pzero;
        logic        lzero;
        logic [30:0] m;
    } t_dv_side;

    // one result bit of the integer square root
    function automatic t_sq sq_step(t_sq a);
        logic [35:0] t;
        logic [35:0] trial;
        t_sq         r;
        t     = {a.rem, a.num[63:62]};
        trial = {2'b00, a.root, 2'b01};
        r.num = {a.num[61:0], 2'b00};
        if (t >= trial) begin
            r.rem  = 34'(t - trial);
            r.root = {a.root[30:0], 1'b1};
        end else begin
            r.rem  = t[33:0];
            r.root = {a.root[30:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit of restoring division
    function automatic t_dv dv_step(t_dv a, logic [31:0] den);
        logic [32:0] t;
        t_dv         r;
        t     = {a.rem, a.num[31]};
        r.num = {a.num[30:0], 1'b0};
        if (t >= {1'b0, den}) begin
            r.rem = 32'(t - {1'b0, den});
            r.q   = {a.q[30:0], 1'b1};
        end else begin
            r.rem = t[31:0];
            r.q   = {a.q[30:0], 1'b0};
        end
        return r;
    endfunction

endpackage

### hw/rtl/csp_if.sv
interface csp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        margin_len;

    modport source (output valid, dir_x, dir_y, dir_z, margin_len, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, margin_len, output ready);
endinterface

interface csp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

### hw/rtl/cone_support_point.sv
// cone support point: farthest point of a Y-axis cone along a direction,
// Q16.16 fixed point, optional margin along the unit direction.
// channels: i_in carries dir_x, dir_y, dir_z and margin_len; o_out carries
// point_x, point_y, point_z, saturated to the signed 32-bit range.
// both use valid/ready; an item moves at a clock edge with both high.
// configuration: APB write of cone_radius (0x0), half_height (0x4) and
// sin_apex (0x8); write only while no item is in flight.
// pipeline: 70 register stages from acceptance to o_out.valid (the first
// loaded at the accepting edge): input register, squares and products,
// sums, 32 square-root stages, two apex-test stages, 32 divider stages,
// then the output register.
// throughput: one item per cycle while o_out is not stalled; every stage holds one item.
// when the receiver stalls with a result waiting, the whole pipeline
// freezes and i_in.ready drops in the same cycle; nothing is lost.
// reset (synchronous, active low) clears all valid bits and loads the
// register defaults: radius 1.0, half height 1.0, sin_apex 29309.
module cone_support_point
    import csp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    csp_in_if.sink      i_in,
    csp_out_if.source   o_out
);

    t_cfg cfg;
    logic en;

    csp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic               r_o_vld;
    logic signed [31:0] r_o_x, r_o_y, r_o_z;

    assign en          = !r_o_vld || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_o_vld;
    assign o_out.point_x = r_o_x;
    assign o_out.point_y = r_o_y;
    assign o_out.point_z = r_o_z;

    // input register
    logic               r_p1_vld;
    logic signed [31:0] r_p1_x, r_p1_y, r_p1_z;
    logic [30:0]        r_p1_m;

    // squares and products
    logic               r_p2_vld;
    logic [63:0]        r_p2_xx, r_p2_yy, r_p2_zz;
    t_sq_side           r_p2_side;

    // sums into the square roots
    logic               r_p3_vld;
    logic [63:0]        r_p3_s, r_p3_sxz;
    t_sq_side           r_p3_side;

    logic [31:0] ax, ay, az;
    assign ax = r_p1_x[31] ? 32'(-r_p1_x) : 32'(r_p1_x);
    assign ay = r_p1_y[31] ? 32'(-r_p1_y) : 32'(r_p1_y);
    assign az = r_p1_z[31] ? 32'(-r_p1_z) : 32'(r_p1_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld <= i_in.valid;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_x <= i_in.dir_x;
            r_p1_y <= i_in.dir_y;
            r_p1_z <= i_in.dir_z;
            r_p1_m <= i_in.margin_len;

            r_p2_xx <= 64'(ax * ax);
            r_p2_yy <= 64'(ay * ay);
            r_p2_zz <= 64'(az * az);
            r_p2_side.sx <= r_p1_x[31];
            r_p2_side.sy <= r_p1_y[31];
            r_p2_side.sz <= r_p1_z[31];
            r_p2_side.y  <= r_p1_y;
            r_p2_side.m  <= r_p1_m;
            r_p2_side.prod[LN_RX] <= 63'(ax * cfg.radius);
            r_p2_side.prod[LN_RZ] <= 63'(az * cfg.radius);
            r_p2_side.prod[LN_MX] <= 63'(ax * r_p1_m);
            r_p2_side.prod[LN_MY] <= 63'(ay * r_p1_m);
            r_p2_side.prod[LN_MZ] <= 63'(az * r_p1_m);

            r_p3_sxz  <= r_p2_xx + r_p2_zz;
            r_p3_s    <= r_p2_xx + r_p2_zz + r_p2_yy;
            r_p3_side <= r_p2_side;
        end
    end

    logic        sq_vld;
    logic [31:0] sq_len, sq_p;
    t_sq_side    sq_side;

    csp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_p3_vld),
        .i_s     (r_p3_s),
        .i_sxz   (r_p3_sxz),
        .i_side  (r_p3_side),
        .o_vld   (sq_vld),
        .o_len   (sq_len),
        .o_p     (sq_p),
        .o_side  (sq_side)
    );

    // apex test: sin_apex * len, then compare
    logic        r_d1_vld;
    logic [47:0] r_d1_prod;
    logic [31:0] r_d1_len, r_d1_p;
    t_sq_side    r_d1_side;

    logic                   r_d2_vld;
    logic [NLANE-1:0][62:0] r_d2_num;
    logic [NLANE-1:0][31:0] r_d2_den;
    t_dv_side               r_d2_side;

    logic apex;
    assign apex = $signed({r_d1_side.y, 16'h0}) >= $signed({1'b0, r_d1_prod});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld <= 1'b0;
            r_d2_vld <= 1'b0;
        end else if (en) begin
            r_d1_vld <= sq_vld;
            r_d2_vld <= r_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_prod <= 48'(cfg.sin_apex * sq_len);
            r_d1_len  <= sq_len;
            r_d1_p    <= sq_p;
            r_d1_side <= sq_side;

            r_d2_num <= r_d1_side.prod;
            for (int l = 0; l < NLANE; l++) begin
                if (l == LN_RX || l == LN_RZ)
                    r_d2_den[l] <= (apex || r_d1_p == 32'd0) ? 32'd1 : r_d1_p;
                else
                    r_d2_den[l] <= (r_d1_len == 32'd0) ? 32'd1 : r_d1_len;
            end
            r_d2_side.sx    <= r_d1_side.sx;
            r_d2_side.sy    <= r_d1_side.sy;
            r_d2_side.sz    <= r_d1_side.sz;
            r_d2_side.apex  <= apex;
            r_d2_side.pzero <= (r_d1_p == 32'd0);
            r_d2_side.lzero <= (r_d1_len == 32'd0);
            r_d2_side.m     <= r_d1_side.m;
        end
    end

    logic                   dv_vld;
    logic [NLANE-1:0][31:0] dv_q;
    t_dv_side               dv_side;

    csp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_d2_vld),
        .i_num   (r_d2_num),
        .i_den   (r_d2_den),
        .i_side  (r_d2_side),
        .o_vld   (dv_vld),
        .o_q     (dv_q),
        .o_side  (dv_side)
    );

    // final sums and saturation
    logic signed [33:0] qs [NLANE];
    logic signed [33:0] px, py, pz;
    logic signed [33:0] hh, rr, mm;

    always_comb begin
        qs[LN_RX] = dv_side.sx ? -$signed({2'b00, dv_q[LN_RX]}) : $signed({2'b00, dv_q[LN_RX]});
        qs[LN_RZ] = dv_side.sz ? -$signed({2'b00, dv_q[LN_RZ]}) : $signed({2'b00, dv_q[LN_RZ]});
        qs[LN_MX] = dv_side.sx ? -$signed({2'b00, dv_q[LN_MX]}) : $signed({2'b00, dv_q[LN_MX]});
        qs[LN_MY] = dv_side.sy ? -$signed({2'b00, dv_q[LN_MY]}) : $signed({2'b00, dv_q[LN_MY]});
        qs[LN_MZ] = dv_side.sz ? -$signed({2'b00, dv_q[LN_MZ]}) : $signed({2'b00, dv_q[LN_MZ]});
        hh = $signed({3'b000, cfg.height});
        rr = $signed({3'b000, cfg.radius});
        mm = $signed({3'b000, dv_side.m});

        if (dv_side.apex) begin
            px = '0;
            py = hh;
            pz = '0;
        end else if (dv_side.pzero) begin
            px = rr;
            py = -hh;
            pz = '0;
        end else begin
            px = qs[LN_RX];
            py = -hh;
            pz = qs[LN_RZ];
        end

        if (dv_side.m != 31'd0) begin
            if (dv_side.lzero) begin
                py = py - mm;
            end else begin
                px = px + qs[LN_MX];
                py = py + qs[LN_MY];
                pz = pz + qs[LN_MZ];
            end
        end
    end

    function automatic logic signed [31:0] sat(logic signed [33:0] v);
        if (v > SAT_MAX) return 32'sh7FFFFFFF;
        if (v < SAT_MIN) return 32'sh80000000;
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_x <= sat(px);
            r_o_y <= sat(py);
            r_o_z <= sat(pz);
        end
    end

endmodule

### hw/rtl/csp_cfg.sv
module csp_cfg
    import csp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius   <= RST_RADIUS;
            r_cfg.height   <= RST_HEIGHT;
            r_cfg.sin_apex <= RST_SIN;
        end else if (wr) begin
            case (paddr[3:2])
                REG_RADIUS: r_cfg.radius   <= pwdata[30:0];
                REG_HEIGHT: r_cfg.height   <= pwdata[30:0];
                REG_SIN:    r_cfg.sin_apex <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RADIUS: prdata = {1'b0, r_cfg.radius};
            REG_HEIGHT: prdata = {1'b0, r_cfg.height};
            REG_SIN:    prdata = {16'h0, r_cfg.sin_apex};
            default:    prdata = 32'h0;
        endcase
    end

endmodule

### hw/rtl/csp_sqrt.sv
module csp_sqrt
    import csp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [63:0] i_s,
    input  logic [63:0] i_sxz,
    input  t_sq_side    i_side,
    output logic        o_vld,
    output logic [31:0] o_len,
    output logic [31:0] o_p,
    output t_sq_side    o_side
);

    logic     r_vld  [NSQ];
    t_sq      r_a    [NSQ];
    t_sq      r_b    [NSQ];
    t_sq_side r_side [NSQ];
    t_sq      n_a    [NSQ];
    t_sq      n_b    [NSQ];

    always_comb begin
        n_a[0] = sq_step('{rem: '0, root: '0, num: i_s});
        n_b[0] = sq_step('{rem: '0, root: '0, num: i_sxz});
        for (int k = 1; k < NSQ; k++) begin
            n_a[k] = sq_step(r_a[k-1]);
            n_b[k] = sq_step(r_b[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSQ; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NSQ; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NSQ; k++) begin
                r_a[k] <= n_a[k];
                r_b[k] <= n_b[k];
            end
            r_side[0] <= i_side;
            for (int k = 1; k < NSQ; k++) r_side[k] <= r_side[k-1];
        end
    end

    assign o_vld  = r_vld[NSQ-1];
    assign o_len  = r_a[NSQ-1].root;
    assign o_p    = r_b[NSQ-1].root;
    assign o_side = r_side[NSQ-1];

endmodule

### hw/rtl/csp_div.sv
module csp_div
    import csp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [NLANE-1:0][62:0]  i_num,
    input  logic [NLANE-1:0][31:0]  i_den,
    input  t_dv_side                i_side,
    output logic                    o_vld,
    output logic [NLANE-1:0][31:0]  o_q,
    output t_dv_side                o_side
);

    logic                   r_vld  [NDIV];
    t_dv                    r_dv   [NDIV][NLANE];
    logic [NLANE-1:0][31:0] r_den  [NDIV];
    t_dv_side               r_side [NDIV];
    t_dv                    n_dv   [NDIV][NLANE];

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            n_dv[0][l] = dv_step('{rem: {1'b0, i_num[l][62:32]},
                                   num: i_num[l][31:0], q: '0}, i_den[l]);
        end
        for (int k = 1; k < NDIV; k++) begin
            for (int l = 0; l < NLANE; l++) begin
                n_dv[k][l] = dv_step(r_dv[k-1][l], r_den[k-1][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NDIV; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NDIV; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NDIV; k++) begin
                for (int l = 0; l < NLANE; l++) r_dv[k][l] <= n_dv[k][l];
            end
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int k = 1; k < NDIV; k++) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < NLANE; l++) o_q[l] = r_dv[NDIV-1][l].q;
    end

    assign o_vld  = r_vld[NDIV-1];
    assign o_side = r_side[NDIV-1];

endmodule

### tb/cone_checker.sv
`timescale 1ns / 100ps

module cone_checker
    import csp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [31:0] cfg_val,
    csp_in_if.sink      in_mon,
    csp_out_if.sink     out_mon,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } t_point;

    logic [30:0] radius_r;
    logic [30:0] height_r;
    logic [15:0] sin_r;
    t_point      point_q[$];

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // trunc(a * k / d) toward zero
    function automatic longint scaled(longint a, logic [63:0] k, logic [63:0] d);
        logic [63:0] mg;
        longint      q;
        mg = (a < 0) ? -a : a;
        q  = longint'((mg * k) / d);
        return (a < 0) ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_point support_of(logic signed [31:0] dx, logic signed [31:0] dy,
                                          logic signed [31:0] dz, logic [30:0] m);
        longint      x, y, z, px, py, pz;
        logic [63:0] sxz, len, p;
        t_point      r;
        x = dx; y = dy; z = dz;
        sxz = 64'(x * x) + 64'(z * z);
        len = int_sqrt(sxz + 64'(y * y));
        if (y * 65536 >= longint'({48'd0, sin_r} * len)) begin
            px = 0; py = height_r; pz = 0;
        end else begin
            p  = int_sqrt(sxz);
            py = -longint'(height_r);
            if (p != 0) begin
                px = scaled(x, radius_r, p);
                pz = scaled(z, radius_r, p);
            end else begin
                px = radius_r; pz = 0;
            end
        end
        if (m != 0) begin
            if (len != 0) begin
                px += scaled(x, m, len);
                py += scaled(y, m, len);
                pz += scaled(z, m, len);
            end else begin
                py -= m;
            end
        end
        r.px = clamp32(px); r.py = clamp32(py); r.pz = clamp32(pz);
        return r;
    endfunction

    assign o_pending = point_q.size();

    always @(posedge i_clk) begin
        t_point e;
        if (!i_rst_n) begin
            radius_r <= RST_RADIUS;
            height_r <= RST_HEIGHT;
            sin_r    <= RST_SIN;
            o_fail_count <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_RADIUS: radius_r <= cfg_val[30:0];
                    REG_HEIGHT: height_r <= cfg_val[30:0];
                    REG_SIN:    sin_r    <= cfg_val[15:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                point_q.push_back(support_of(in_mon.dir_x, in_mon.dir_y, in_mon.dir_z,
                                             in_mon.margin_len));
            if (out_mon.valid && out_mon.ready) begin
                if (point_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected point %h %h %h", out_mon.point_x,
                                 out_mon.point_y, out_mon.point_z);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = point_q.pop_front();
                    if (e.px !== out_mon.point_x || e.py !== out_mon.point_y
                            || e.pz !== out_mon.point_z) begin
                        if (o_fail_count < 10)
                            $display("point mismatch: exp %h %h %h got %h %h %h",
                                     e.px, e.py, e.pz, out_mon.point_x,
                                     out_mon.point_y, out_mon.point_z);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import csp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, cycle_cnt;
    int          src_idle_pct, snk_stall_pct, hold_cycles;
    logic        cfg_we;

    csp_in_if  in_ch();
    csp_out_if out_ch();

    cone_support_point dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    assign cfg_we = psel && penable && pwrite && pready;

    cone_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .cfg_we(cfg_we), .cfg_idx(paddr[3:2]),
        .cfg_val(pwdata), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #6;
        i_clk = 1'b1; #6;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 600000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // valid stays high after an accepted item until the next call or drain
    task automatic send_dir(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                            logic [30:0] m);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.dir_x <= dx; in_ch.dir_y <= dy; in_ch.dir_z <= dz;
        in_ch.margin_len <= m;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072)) - 65536);
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            3: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom_range(1) ? 32'($urandom_range(16)) : 32'd0;
        endcase
    endfunction

    function automatic logic [30:0] rand_margin();
        case ($urandom_range(3))
            0: return 31'd0;
            1: return 31'($urandom);
            2: return 31'($urandom_range(131072));
            default: return 31'h7fffffff;
        endcase
    endfunction

    task automatic random_dirs(int n);
        for (int k = 0; k < n; k++)
            send_dir(rand_comp(), rand_comp(), rand_comp(), rand_margin());
    endtask

    initial begin
        cycle_cnt = 0; hold_cycles = 0;
        src_idle_pct = 0; snk_stall_pct = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_ch.valid = 0; in_ch.dir_x = 0; in_ch.dir_y = 0; in_ch.dir_z = 0;
        in_ch.margin_len = 0; out_ch.ready = 1'b1;
        i_rst_n = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero direction, apex, rim, zero projection, extremes
        send_dir(0, 0, 0, 0);
        send_dir(0, 0, 0, 31'd65536);
        send_dir(0, 32'h00010000, 0, 0);
        send_dir(0, 32'hffff0000, 0, 0);
        send_dir(0, 32'hffff0000, 0, 31'h7fffffff);
        send_dir(32'h00010000, 0, 0, 0);
        send_dir(0, 0, 32'hffff0000, 31'd100);
        send_dir(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
        send_dir(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
        send_dir(32'h80000000, 32'h7fffffff, 32'h80000000, 31'd1);
        send_dir(32'hffffffff, 32'h00000001, 32'hffffffff, 31'h55555555);
        send_dir(32'h00000001, 32'hfffffffe, 0, 31'h2aaaaaaa);
        send_dir(32'h12345678, 32'hedcba987, 32'h0f0f0f0f, 31'h7fffffff);
        drain();

        apb_write(REG_RADIUS, 32'h7fffffff);
        apb_write(REG_HEIGHT, 32'h7fffffff);
        apb_write(REG_SIN, 32'h0000ffff);
        send_dir(32'h7fffffff, 32'h80000000, 0, 31'h7fffffff);
        send_dir(32'h80000000, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
        random_dirs(200);
        drain();

        apb_write(REG_RADIUS, 32'd1);
        apb_write(REG_HEIGHT, 32'd1);
        apb_write(REG_SIN, 32'd1);
        src_idle_pct = 74;
        random_dirs(200);
        drain();

        apb_write(REG_RADIUS, 32'd0);
        apb_write(REG_HEIGHT, 32'd0);
        apb_write(REG_SIN, 32'd0);
        src_idle_pct = 0; snk_stall_pct = 74;
        random_dirs(150);
        drain();

        apb_write(REG_RADIUS, $urandom);
        apb_write(REG_HEIGHT, $urandom);
        apb_write(REG_SIN, $urandom);
        src_idle_pct = 17; snk_stall_pct = 17;
        random_dirs(250);
        drain();

        // long receiver hold-off so the pipeline fills and stalls input
        apb_write(REG_RADIUS, 32'd65536);
        apb_write(REG_HEIGHT, 32'd131072);
        apb_write(REG_SIN, 32'd29309);
        src_idle_pct = 0; snk_stall_pct = 0;
        hold_cycles = 300;
        random_dirs(150);
        drain();
        random_dirs(150);
        drain();
        repeat (20) @(negedge i_clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
